// ----- rtl/psfc_pkg.sv -----
// Shared constants and the per-packet beat type for the per-source flood counter.
package psfc_pkg;

    localparam int TABLE_ENTRIES = 64;

    localparam int PROTO_W    = 8;
    localparam int ADDR_W     = 32;
    localparam int COUNT_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [PROTO_W-1:0] UDP_PROTOCOL    = 8'd17;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 16'hFFFF;
    localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 16'd100;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HOST_ADDRESS     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_THRESHOLD = 1'd1;

    // One packet as it travels down the row of table cells
    typedef struct packed {
        logic               active;    // a packet occupies this slot
        logic               eligible;  // UDP to the protected host
        logic               resolved;  // no further cell may touch it
        logic               counted;   // an entry took the packet
        logic               report;    // count went over the threshold
        logic [ADDR_W-1:0]  source;
        logic [COUNT_W-1:0] count;     // count after counting, before clearing
    } psfc_beat_t;

endpackage

// ----- rtl/psfc_cell.sv -----
// One table entry of the flood counter: holds a source and its count, passes the packet on.
module psfc_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  psfc_pkg::psfc_beat_t          beat_in,
    input  logic [psfc_pkg::COUNT_W-1:0]  report_threshold,
    output psfc_pkg::psfc_beat_t          beat_out
);
    import psfc_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [ADDR_W-1:0]  source_reg;
    logic [ADDR_W-1:0]  source_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    psfc_beat_t         beat_reg;
    psfc_beat_t         beat_next;

    logic               probe;
    logic               claim;
    logic               hit;
    logic [COUNT_W-1:0] bumped;
    logic [COUNT_W-1:0] new_count;
    logic               over;

    always_comb
    begin
        probe     = beat_in.active && beat_in.eligible && !beat_in.resolved;
        claim     = probe && !valid_reg;
        hit       = probe && valid_reg && (source_reg == beat_in.source);
        // saturate at the top of the range
        bumped    = (count_reg == COUNT_MAX) ? count_reg : COUNT_W'(count_reg + 16'd1);
        new_count = claim ? 16'd1 : bumped;
        over      = new_count > report_threshold;

        valid_next  = valid_reg;
        source_next = source_reg;
        count_next  = count_reg;
        beat_next   = beat_in;

        if (claim || hit)
        begin
            valid_next         = 1'b1;
            source_next        = beat_in.source;
            count_next         = over ? '0 : new_count;
            beat_next.resolved = 1'b1;
            beat_next.counted  = 1'b1;
            beat_next.count    = new_count;
            beat_next.report   = over;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            beat_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            beat_reg  <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        source_reg <= source_next;
        count_reg  <= count_next;
    end

    assign beat_out = beat_reg;

    // A cell that takes a packet must resolve it on the way out
    assert property (@(posedge clk) disable iff (!rst_n)
        (claim || hit) |=> (beat_out.resolved && beat_out.counted))
        else $error("psfc_cell: taken packet not resolved");

    // A cleared count follows every report
    assert property (@(posedge clk) disable iff (!rst_n)
        ((claim || hit) && over) |=> (count_reg == '0))
        else $error("psfc_cell: reported count not cleared");

    // Once filled, an entry stays valid until reset
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |=> valid_reg)
        else $error("psfc_cell: entry freed without reset");

endmodule

// ----- rtl/per_source_flood_counter.sv -----
// Per-source flood counter: top level with config registers, intake stage and cell row.
// Throughput: one packet per cycle; busy stays low, each packet walks the cell row one
//   entry per cycle, so a later packet always meets every entry after the earlier one.
// The result latency is set by the intake register and the length of the cell row, one register per table entry.
// Reset (rst_n, async, active low) empties the table, sets host_address to 0 and
//   report_threshold to 100; results cannot be stalled, so none are ever held back.
module per_source_flood_counter
(
    input  logic                              clk,
    input  logic                              rst_n,
    // command side
    input  logic                              start,
    output logic                              busy,
    input  logic [psfc_pkg::PROTO_W-1:0]      protocol_number,
    input  logic [psfc_pkg::ADDR_W-1:0]       source_address,
    input  logic [psfc_pkg::ADDR_W-1:0]       destination_address,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [psfc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [psfc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // result side
    output logic                              result_valid,
    output logic                              was_counted,
    output logic [psfc_pkg::COUNT_W-1:0]      source_count,
    output logic                              report_attack,
    output logic [psfc_pkg::ADDR_W-1:0]       attacker_address,
    output logic                              table_full
);
    import psfc_pkg::*;

    localparam int LATENCY = TABLE_ENTRIES + 1;

    logic [ADDR_W-1:0]  host_reg;
    logic [ADDR_W-1:0]  host_next;
    logic [COUNT_W-1:0] threshold_reg;
    logic [COUNT_W-1:0] threshold_next;
    psfc_beat_t         intake_reg;
    psfc_beat_t         intake_next;
    logic               accept;

    // beat[0] is the intake stage, beat[i+1] leaves cell i
    psfc_beat_t         beat [0:TABLE_ENTRIES];
    psfc_beat_t         tail;

    // The row never stalls, so a new packet is taken on every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Configuration writes: unknown indexes drop the beat
    always_comb
    begin
        host_next      = host_reg;
        threshold_next = threshold_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_HOST_ADDRESS:     host_next      = cfg_wdata[ADDR_W-1:0];
                CFG_REPORT_THRESHOLD: threshold_next = cfg_wdata[COUNT_W-1:0];
                default:
                begin
                    host_next      = host_reg;
                    threshold_next = threshold_reg;
                end
            endcase
        end
    end

    // Intake: decide up front whether the packet is UDP to the protected host.
    // Packets that are not get marked resolved and ride the row untouched,
    // which keeps results in arrival order.
    always_comb
    begin
        intake_next          = '0;
        intake_next.active   = accept;
        intake_next.eligible = (protocol_number == UDP_PROTOCOL) &&
                               (destination_address == host_reg);
        intake_next.resolved = !intake_next.eligible;
        intake_next.source   = source_address;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host_reg      <= '0;
            threshold_reg <= THRESHOLD_RESET;
            intake_reg    <= '0;
        end
        else
        begin
            host_reg      <= host_next;
            threshold_reg <= threshold_next;
            intake_reg    <= intake_next;
        end
    end

    assign beat[0] = intake_reg;

    // Row of table cells. Entries fill lowest first and are never freed, so the
    // first empty cell a packet meets is the lowest free entry and no known
    // source can sit beyond it.
    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        psfc_cell u_cell
        (
            .clk              (clk),
            .rst_n            (rst_n),
            .beat_in          (beat[i]),
            .report_threshold (threshold_reg),
            .beat_out         (beat[i+1])
        );
    end

    // Result from the end of the row; a packet still unresolved found no room
    assign tail             = beat[TABLE_ENTRIES];
    assign result_valid     = tail.active;
    assign was_counted      = tail.active && tail.counted;
    assign source_count     = (tail.active && tail.counted) ? tail.count : '0;
    assign report_attack    = tail.active && tail.counted && tail.report;
    assign attacker_address = (tail.active && tail.eligible) ? tail.source : '0;
    assign table_full       = tail.active && tail.eligible && !tail.resolved;

    // Every start beat yields one result after the fixed row latency
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY result_valid)
        else $error("per_source_flood_counter: result missing after accept");

    // A report only comes with a counted packet
    assert property (@(posedge clk) disable iff (!rst_n)
        report_attack |-> (was_counted && result_valid))
        else $error("per_source_flood_counter: report without count");

    // A dropped packet is never counted
    assert property (@(posedge clk) disable iff (!rst_n)
        table_full |-> (!was_counted && (source_count == '0) && !report_attack))
        else $error("per_source_flood_counter: dropped packet counted");

    // A counted packet carries a non-zero count
    assert property (@(posedge clk) disable iff (!rst_n)
        was_counted |-> (source_count != '0))
        else $error("per_source_flood_counter: counted packet with zero count");

endmodule
